[rtl/v3n_pkg.sv]
`timescale 1ns / 1ps
package v3n_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 32;
  localparam int unsigned LATENCY     = 3 + SQRT_STAGES + DIV_STAGES + 1;

  // per item side data carried beside the dividers
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [31:0] len;
  } v3n_side_t;

endpackage

[rtl/v3n_div_pipe.sv]
`timescale 1ns / 1ps
module v3n_div_pipe (
  input  logic        clk_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quo_o
);
  import v3n_pkg::*;

  // quotient is known to fit in 32 bits, so num[63:32] < den
  logic [31:0] rem_q [DIV_STAGES];
  logic [31:0] lo_q  [DIV_STAGES];
  logic [31:0] quo_q [DIV_STAGES];
  logic [31:0] den_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [31:0] rem_in, lo_in, quo_in, den_in;
    logic [32:0] trial;
    logic [32:0] diff;

    if (j == 0) begin : g_first
      assign rem_in = num_i[63:32];
      assign lo_in  = num_i[31:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end

    assign trial = {rem_in, lo_in[31]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, den_in}) begin
        rem_q[j] <= diff[31:0];
        quo_q[j] <= {quo_in[30:0], 1'b1};
      end else begin
        rem_q[j] <= trial[31:0];
        quo_q[j] <= {quo_in[30:0], 1'b0};
      end
      lo_q[j]  <= {lo_in[30:0], 1'b0};
      den_q[j] <= den_in;
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

[rtl/vector3_normalize_scale_unit.sv]
`timescale 1ns / 1ps
// pipeline: 3 front stages, 32 square root stages at one root bit each, 32 divider stages
// at one quotient bit each, 1 output stage; done_o is high in the cycle the outputs are valid
// throughput: one item per cycle, busy_o stays low; the receiver cannot stall
// reset: rst_ni async active low clears the valid pipeline, no item in flight
module vector3_normalize_scale_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] scale_factor_i,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        [31:0] magnitude_o,
  output logic               was_zero_o
);
  import v3n_pkg::*;

  assign busy_o = 1'b0;

  logic [LATENCY-1:0] valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LATENCY-2:0], start_i};
    end
  end

  // stage 1: magnitudes and signs
  logic [31:0] ax_q, ay_q, az_q, ab_q;
  logic        nx_q, ny_q, nz_q, ns_q;
  always_ff @(posedge clk_i) begin
    ax_q <= vec_x_i[31] ? 32'(-vec_x_i) : vec_x_i;
    ay_q <= vec_y_i[31] ? 32'(-vec_y_i) : vec_y_i;
    az_q <= vec_z_i[31] ? 32'(-vec_z_i) : vec_z_i;
    ab_q <= scale_factor_i[31] ? 32'(-scale_factor_i) : scale_factor_i;
    nx_q <= vec_x_i[31];
    ny_q <= vec_y_i[31];
    nz_q <= vec_z_i[31];
    ns_q <= scale_factor_i[31];
  end

  // stage 2: squares and scaled products
  logic [63:0] sqx_q, sqy_q, sqz_q, px_q, py_q, pz_q;
  logic        ngx_q, ngy_q, ngz_q;
  always_ff @(posedge clk_i) begin
    sqx_q <= 64'(ax_q) * 64'(ax_q);
    sqy_q <= 64'(ay_q) * 64'(ay_q);
    sqz_q <= 64'(az_q) * 64'(az_q);
    px_q  <= 64'(ax_q) * 64'(ab_q);
    py_q  <= 64'(ay_q) * 64'(ab_q);
    pz_q  <= 64'(az_q) * 64'(ab_q);
    ngx_q <= nx_q ^ ns_q;
    ngy_q <= ny_q ^ ns_q;
    ngz_q <= nz_q ^ ns_q;
  end

  // stage 3: sum of squares
  logic [63:0] sum_q, p3x_q, p3y_q, p3z_q;
  logic        n3x_q, n3y_q, n3z_q;
  always_ff @(posedge clk_i) begin
    sum_q <= sqx_q + sqy_q + sqz_q;
    p3x_q <= px_q;
    p3y_q <= py_q;
    p3z_q <= pz_q;
    n3x_q <= ngx_q;
    n3y_q <= ngy_q;
    n3z_q <= ngz_q;
  end

  // square root stages, products and signs ride along
  logic [63:0] rem_q  [SQRT_STAGES];
  logic [63:0] root_q [SQRT_STAGES];
  logic [63:0] spx_q  [SQRT_STAGES];
  logic [63:0] spy_q  [SQRT_STAGES];
  logic [63:0] spz_q  [SQRT_STAGES];
  logic [2:0]  sng_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in, root_in, px_in, py_in, pz_in, trial;
    logic [2:0]  ng_in;

    if (k == 0) begin : g_first
      assign rem_in  = sum_q;
      assign root_in = '0;
      assign px_in   = p3x_q;
      assign py_in   = p3y_q;
      assign pz_in   = p3z_q;
      assign ng_in   = {n3x_q, n3y_q, n3z_q};
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign px_in   = spx_q[k-1];
      assign py_in   = spy_q[k-1];
      assign pz_in   = spz_q[k-1];
      assign ng_in   = sng_q[k-1];
    end

    assign trial = root_in + Bit;

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= (root_in >> 1) + Bit;
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in >> 1;
      end
      spx_q[k] <= px_in;
      spy_q[k] <= py_in;
      spz_q[k] <= pz_in;
      sng_q[k] <= ng_in;
    end
  end

  logic [31:0] len;
  assign len = root_q[SQRT_STAGES-1][31:0];

  logic [31:0] qx, qy, qz;

  v3n_div_pipe u_div_x (
    .clk_i (clk_i),
    .num_i (spx_q[SQRT_STAGES-1]),
    .den_i (len),
    .quo_o (qx)
  );

  v3n_div_pipe u_div_y (
    .clk_i (clk_i),
    .num_i (spy_q[SQRT_STAGES-1]),
    .den_i (len),
    .quo_o (qy)
  );

  v3n_div_pipe u_div_z (
    .clk_i (clk_i),
    .num_i (spz_q[SQRT_STAGES-1]),
    .den_i (len),
    .quo_o (qz)
  );

  v3n_side_t side_q [DIV_STAGES];
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        side_q[j] <= '{neg_x: sng_q[SQRT_STAGES-1][2],
                       neg_y: sng_q[SQRT_STAGES-1][1],
                       neg_z: sng_q[SQRT_STAGES-1][0],
                       len:   len};
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  function automatic logic [31:0] sat_sign(input logic [31:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      // q never exceeds 2^31 here
      r = 32'(-q);
    end else if (q[31]) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = q;
    end
    return r;
  endfunction

  v3n_side_t side_f;
  logic      zero_f;
  assign side_f = side_q[DIV_STAGES-1];
  assign zero_f = (side_f.len == '0);

  logic [31:0] out_x_q, out_y_q, out_z_q, mag_q;
  logic        zero_q;
  always_ff @(posedge clk_i) begin
    out_x_q <= zero_f ? '0 : sat_sign(qx, side_f.neg_x);
    out_y_q <= zero_f ? '0 : sat_sign(qy, side_f.neg_y);
    out_z_q <= zero_f ? '0 : sat_sign(qz, side_f.neg_z);
    mag_q   <= side_f.len;
    zero_q  <= zero_f;
  end

  assign done_o      = valid_q[LATENCY-1];
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign magnitude_o = mag_q;
  assign was_zero_o  = zero_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import v3n_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [31:0] mag;
    logic               zero;
  } norm_res_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic               typed;
    norm_res_t          res;
  } vec_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic signed [31:0] vec_x_i = '0;
  logic signed [31:0] vec_y_i = '0;
  logic signed [31:0] vec_z_i = '0;
  logic signed [31:0] scale_factor_i = '0;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic        [31:0] magnitude_o;
  logic               was_zero_o;

  norm_res_t expected_q[$];
  int        mismatch_cnt = 0;
  int        send_idle_pct = 0;

  vector3_normalize_scale_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem = v;
    root = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // trunc(comp * scale / len) with saturation
  function automatic logic [31:0] scale_div(input logic signed [31:0] c,
                                            input logic signed [31:0] s,
                                            input logic [31:0] len);
    logic [63:0] q;
    q = (64'(mag32(c)) * 64'(mag32(s))) / 64'(len);
    if (c[31] != s[31]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic norm_res_t normalize(input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic signed [31:0] z,
                                          input logic signed [31:0] s);
    norm_res_t r;
    logic [63:0] sum;
    logic [31:0] len;
    sum = 64'(mag32(x)) * mag32(x) + 64'(mag32(y)) * mag32(y) + 64'(mag32(z)) * mag32(z);
    len = 32'(int_sqrt(sum));
    r = '0;
    if (len == 0) begin
      r.zero = 1'b1;
      return r;
    end
    r.x = scale_div(x, s, len);
    r.y = scale_div(y, s, len);
    r.z = scale_div(z, s, len);
    r.mag = len;
    return r;
  endfunction

  task automatic send_vec(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z, input logic signed [31:0] s,
                          input logic typed, input norm_res_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    scale_factor_i <= s;
    expected_q.push_back(typed ? res : normalize(x, y, z, s));
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(255) - 128;
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return 32'sh8000_0000 + $urandom_range(3);
      3: return $urandom_range(32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(4))
      0: return 32'sh0001_0000;
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // results come one cycle wide and cannot be held off
  always @(posedge clk_i) begin
    norm_res_t got;
    norm_res_t exp_r;
    if (rst_ni && done_o) begin
      got = '{out_x_o, out_y_o, out_z_o, magnitude_o, was_zero_o};
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: exp x=%h y=%h z=%h mag=%h zero=%b,",
                      " got x=%h y=%h z=%h mag=%h zero=%b"},
                     exp_r.x, exp_r.y, exp_r.z, exp_r.mag, exp_r.zero,
                     got.x, got.y, got.z, got.mag, got.zero);
        end
      end
    end
  end

  vec_row_t vec_table[] = '{
    '{32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 1'b1, '{0, 0, 0, 0, 1'b1}},
    '{32'sh0, 32'sh0, 32'sh0, 32'sh8000_0000, 1'b1, '{0, 0, 0, 0, 1'b1}},
    '{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0001_0000, 1'b1,
      '{32'sh0001_0000, 0, 0, 32'h0001_0000, 1'b0}},
    '{32'sh0, 32'shFFFF_0000, 32'sh0, 32'sh0001_0000, 1'b1,
      '{0, 32'shFFFF_0000, 0, 32'h0001_0000, 1'b0}},
    '{32'sh0, 32'sh0, 32'sh1, 32'sh0001_0000, 1'b1, '{0, 0, 32'sh0001_0000, 32'h1, 1'b0}},
    '{32'sh1, 32'sh0, 32'sh0, 32'sh8000_0000, 1'b1,
      '{32'sh8000_0000, 0, 0, 32'h1, 1'b0}},
    '{32'shFFFF_FFFF, 32'sh0, 32'sh0, 32'sh8000_0000, 1'b1,
      '{32'sh7FFF_FFFF, 0, 0, 32'h1, 1'b0}},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0001_0000, 1'b0, '0},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 1'b0, '0},
    '{32'sh0003_0000, 32'sh0004_0000, 32'sh0, 32'sh0001_0000, 1'b0, '0},
    '{32'shFFFD_0000, 32'sh0004_0000, 32'sh000C_0000, 32'shFFFE_0000, 1'b0, '0},
    '{32'sh1, 32'sh1, 32'sh1, 32'sh7FFF_FFFF, 1'b0, '0},
    '{32'sh1234_5678, 32'shEDCB_A987, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0},
    '{32'sh0, 32'sh0, 32'sh8000_0000, 32'sh0, 1'b0, '0}
  };

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vec_table[i])
      send_vec(vec_table[i].x, vec_table[i].y, vec_table[i].z, vec_table[i].s,
               vec_table[i].typed, vec_table[i].res);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 10 : 0;
      for (int n = 0; n < 475; n++) begin
        if ($urandom_range(19) == 0)
          send_vec(0, 0, 0, rand_scale(), 1'b0, '0);
        else
          send_vec(rand_comp(), rand_comp(), rand_comp(), rand_scale(), 1'b0, '0);
      end
    end
    start_i <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 10 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
